### rtl/core/priority_bitmap_run_queue_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority bitmap run queue
// Every-clock-edge and next-cycle property checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_BITMAP_RUN_QUEUE_UNIT_ASSERT_SVH
`define PRIORITY_BITMAP_RUN_QUEUE_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset.
`define PBRQ_ASSERT_ALWAYS(lbl, clk_sig, rst_sig, cond) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (cond)) \
    else $error("run queue invariant violated");

// Check that a trigger is followed by a consequence in the next cycle.
`define PBRQ_ASSERT_NEXT(lbl, clk_sig, rst_sig, trig, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (trig) |=> (cons)) \
    else $error("run queue update violated");

`endif

### rtl/core/pbrq_pkg.sv
// ----------------------------------------------------------------------------
// pbrq_pkg
// Request kinds, result codes and fixed field widths of the run queue.
// ----------------------------------------------------------------------------
package pbrq_pkg;

  localparam int KIND_W   = 2;
  localparam int TID_W    = 8;
  localparam int PRIO_W   = 5;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 10;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 2'd0,
    KIND_PUSH_BACK  = 2'd1,
    KIND_POP_FRONT  = 2'd2,
    KIND_POP_BACK   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

endpackage

### rtl/core/priority_bitmap_run_queue_unit.sv
// ----------------------------------------------------------------------------
// priority_bitmap_run_queue_unit
// Per-level double-ended thread queues with an occupancy bitmap; pops serve
// the lowest-numbered non-empty level.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_ready  | kind, thread_id, priority_req
//   out     | out_valid/out_ready| status, popped_id, popped_priority,
//           |                    | total_count
//
// One item per cycle sustained while out_ready is high; a request passes the
// request register, then the result register. The popped id is the registered
// slot memory read data, captured as the item moves into the result register.
// Reset clears head, length, bitmap and count at once; slots are not cleared.
// A stalled result holds the request register, which holds in_ready low.
// ----------------------------------------------------------------------------
`include "priority_bitmap_run_queue_unit_assert.svh"

module priority_bitmap_run_queue_unit #(
  parameter int PRIO_LEVELS     = 32,
  parameter int SLOTS_PER_LEVEL = 16,
  parameter int ID_BITS         = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pbrq_pkg::KIND_W-1:0]      kind,
  input  logic [pbrq_pkg::TID_W-1:0]       thread_id,
  input  logic [pbrq_pkg::PRIO_W-1:0]      priority_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pbrq_pkg::STATUS_W-1:0]    status,
  output logic [pbrq_pkg::TID_W-1:0]       popped_id,
  output logic [pbrq_pkg::PRIO_W-1:0]      popped_priority,
  output logic [pbrq_pkg::TOTAL_W-1:0]     total_count
);

  localparam int LVL_W  = $clog2(PRIO_LEVELS);
  localparam int HEAD_W = $clog2(SLOTS_PER_LEVEL);
  localparam int LEN_W  = $clog2(SLOTS_PER_LEVEL + 1);
  localparam int DEPTH  = PRIO_LEVELS * SLOTS_PER_LEVEL;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = HEAD_W + 1;
  localparam int CMP_W  = 7;

  logic                          a_valid;
  pbrq_pkg::kind_t               a_kind;
  logic [pbrq_pkg::TID_W-1:0]    a_id;
  logic [pbrq_pkg::PRIO_W-1:0]   a_prio;

  logic                          b_valid;
  pbrq_pkg::status_t             b_status;
  logic [LVL_W-1:0]              b_lvl;
  logic [CNT_W-1:0]              b_count;
  logic                          b_pop_ok;

  logic [HEAD_W-1:0]             level_head   [PRIO_LEVELS];
  logic [LEN_W-1:0]              level_length [PRIO_LEVELS];
  logic [PRIO_LEVELS-1:0]        level_bitmap;
  logic [CNT_W-1:0]              queued_total;

  logic [ID_BITS-1:0]            slot_store [DEPTH];
  logic [ID_BITS-1:0]            slot_rdata;

  logic                          advance;
  logic                          is_push;
  logic [LVL_W-1:0]              pop_lvl;
  logic [LVL_W-1:0]              lvl;
  logic [HEAD_W-1:0]             cur_head;
  logic [LEN_W-1:0]              cur_len;
  logic [SUM_W-1:0]              tail_sum;
  logic [SUM_W-1:0]              back_sum;
  logic [HEAD_W-1:0]             pos;
  logic [HEAD_W-1:0]             head_next;
  logic [LEN_W-1:0]              len_next;
  logic                          head_we;
  logic                          len_we;
  logic [PRIO_LEVELS-1:0]        level_bitmap_next;
  logic [CNT_W-1:0]              queued_total_next;
  pbrq_pkg::status_t             status_next;
  logic                          pop_ok;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_addr;
  logic [PRIO_LEVELS-1:0]        level_busy;

  assign advance  = a_valid && (!b_valid || out_ready);
  assign in_ready = !a_valid || advance;
  assign is_push  = (a_kind == pbrq_pkg::KIND_PUSH_FRONT) ||
                    (a_kind == pbrq_pkg::KIND_PUSH_BACK);

  always_comb begin
    pop_lvl = '0;
    for (int i = PRIO_LEVELS - 1; i >= 0; i--) begin
      if (level_bitmap[i]) begin
        pop_lvl = LVL_W'(i);
      end
    end
  end

  always_comb begin
    if (is_push) begin
      if ({2'b00, a_prio} >= CMP_W'(PRIO_LEVELS)) begin
        lvl = LVL_W'(PRIO_LEVELS - 1);
      end else begin
        lvl = LVL_W'(a_prio);
      end
    end else begin
      lvl = pop_lvl;
    end
  end

  assign cur_head = level_head[lvl];
  assign cur_len  = level_length[lvl];
  assign tail_sum = SUM_W'(cur_head) + SUM_W'(cur_len);
  assign back_sum = tail_sum - SUM_W'(1);

  always_comb begin
    status_next       = pbrq_pkg::STATUS_OK;
    pop_ok            = 1'b0;
    head_we           = 1'b0;
    len_we            = 1'b0;
    mem_we            = 1'b0;
    pos               = cur_head;
    head_next         = cur_head;
    len_next          = cur_len;
    level_bitmap_next = level_bitmap;
    queued_total_next = queued_total;
    case (a_kind)
      pbrq_pkg::KIND_PUSH_FRONT, pbrq_pkg::KIND_PUSH_BACK: begin
        if (cur_len >= LEN_W'(SLOTS_PER_LEVEL)) begin
          status_next = pbrq_pkg::STATUS_FULL;
        end else begin
          if (a_kind == pbrq_pkg::KIND_PUSH_FRONT) begin
            if (cur_head == '0) begin
              head_next = HEAD_W'(SLOTS_PER_LEVEL - 1);
            end else begin
              head_next = cur_head - HEAD_W'(1);
            end
            pos     = head_next;
            head_we = 1'b1;
          end else if (tail_sum >= SUM_W'(SLOTS_PER_LEVEL)) begin
            pos = HEAD_W'(tail_sum - SUM_W'(SLOTS_PER_LEVEL));
          end else begin
            pos = HEAD_W'(tail_sum);
          end
          mem_we                 = 1'b1;
          len_next               = cur_len + LEN_W'(1);
          len_we                 = 1'b1;
          level_bitmap_next[lvl] = 1'b1;
          queued_total_next      = queued_total + CNT_W'(1);
        end
      end
      pbrq_pkg::KIND_POP_FRONT, pbrq_pkg::KIND_POP_BACK: begin
        if (level_bitmap == '0) begin
          status_next = pbrq_pkg::STATUS_EMPTY;
        end else if (cur_len == '0) begin
          status_next            = pbrq_pkg::STATUS_EMPTY;
          level_bitmap_next[lvl] = 1'b0;
        end else begin
          if (a_kind == pbrq_pkg::KIND_POP_FRONT) begin
            if (cur_head == HEAD_W'(SLOTS_PER_LEVEL - 1)) begin
              head_next = '0;
            end else begin
              head_next = cur_head + HEAD_W'(1);
            end
            head_we = 1'b1;
          end else if (back_sum >= SUM_W'(SLOTS_PER_LEVEL)) begin
            pos = HEAD_W'(back_sum - SUM_W'(SLOTS_PER_LEVEL));
          end else begin
            pos = HEAD_W'(back_sum);
          end
          pop_ok   = 1'b1;
          len_next = cur_len - LEN_W'(1);
          len_we   = 1'b1;
          if (cur_len == LEN_W'(1)) begin
            level_bitmap_next[lvl] = 1'b0;
          end
          if (queued_total != '0) begin
            queued_total_next = queued_total - CNT_W'(1);
          end
        end
      end
      default: begin
        status_next = pbrq_pkg::STATUS_OK;
      end
    endcase
  end

  assign mem_addr = ADDR_W'(ADDR_W'(lvl) * ADDR_W'(SLOTS_PER_LEVEL)) + ADDR_W'(pos);

  always_ff @(posedge clk) begin
    if (advance && mem_we) begin
      slot_store[mem_addr] <= ID_BITS'(a_id);
    end
    if (advance && pop_ok) begin
      slot_rdata <= slot_store[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level_bitmap <= '0;
      queued_total <= '0;
      for (int i = 0; i < PRIO_LEVELS; i++) begin
        level_head[i]   <= '0;
        level_length[i] <= '0;
      end
    end else if (advance) begin
      if (head_we) begin
        level_head[lvl] <= head_next;
      end
      if (len_we) begin
        level_length[lvl] <= len_next;
      end
      level_bitmap <= level_bitmap_next;
      queued_total <= queued_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (advance) begin
        b_valid <= 1'b1;
      end else if (out_ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_kind <= pbrq_pkg::kind_t'(kind);
      a_id   <= thread_id;
      a_prio <= priority_req;
    end
    if (advance) begin
      b_status <= status_next;
      b_lvl    <= lvl;
      b_count  <= queued_total_next;
      b_pop_ok <= pop_ok;
    end
  end

  assign out_valid       = b_valid;
  assign status          = b_status;
  assign popped_id       = b_pop_ok ? pbrq_pkg::TID_W'(slot_rdata) : '0;
  assign popped_priority = b_pop_ok ? pbrq_pkg::PRIO_W'(b_lvl) : '0;
  assign total_count     = pbrq_pkg::TOTAL_W'(b_count);

  for (genvar g = 0; g < PRIO_LEVELS; g++) begin : g_busy
    assign level_busy[g] = level_length[g] != '0;
  end

  `PBRQ_ASSERT_ALWAYS(a_bitmap_tracks_len, clk, rst, level_bitmap == level_busy)
  `PBRQ_ASSERT_NEXT(a_push_counts, clk, rst,
    advance && is_push && (status_next == pbrq_pkg::STATUS_OK),
    queued_total == $past(queued_total) + CNT_W'(1))
  `PBRQ_ASSERT_NEXT(a_pop_counts, clk, rst, advance && pop_ok,
    queued_total == $past(queued_total) - CNT_W'(1))

endmodule
